// File: rtl/core/modexp_pkg.sv
// Shared types and constants of the modular exponentiation block.
`default_nettype none
package modexp_pkg;

  localparam int unsigned FIELD_BITS       = 32;
  localparam int unsigned OPERAND_BITS_DEF = 32;

  typedef enum logic [1:0] {
    SEL_REDUCE,
    SEL_ACC,
    SEL_SQUARE
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     wr_acc;
    logic     wr_sq;
    logic     shift;
  } ctrl_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic exp_rest_zero;
    logic mul_busy;
    logic mul_done;
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/core/modexp_mulmod.sv
// Iterative modular multiplier: one bit of b per cycle, MSB first.
`default_nettype none
module modexp_mulmod import modexp_pkg::*; #(
  parameter int unsigned W = OPERAND_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic [W-1:0] m_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [W-1:0]      result_o
);

  localparam int unsigned CntW = $clog2(W);

  logic            active_q, active_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    r_q, r_d;
  logic [W-1:0]    a_q, a_d;
  logic [W-1:0]    b_q, b_d;

  // x + y mod m for x, y < m
  function automatic logic [W-1:0] add_mod(logic [W-1:0] x, logic [W-1:0] y,
                                           logic [W-1:0] m);
    logic [W-1:0] gap;
    gap = m - y;
    if (x >= gap) begin
      return x - gap;
    end
    return x + y;
  endfunction

  logic [W-1:0] r_dbl;
  logic [W-1:0] r_step;

  assign r_dbl  = add_mod(r_q, r_q, m_i);
  assign r_step = b_q[W-1] ? add_mod(r_dbl, a_q, m_i) : r_dbl;

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    r_d      = r_q;
    a_d      = a_q;
    b_d      = b_q;
    if (start_i && !active_q) begin
      active_d = 1'b1;
      cnt_d    = CntW'(W - 1);
      r_d      = '0;
      a_d      = a_i;
      b_d      = b_i;
    end else if (active_q) begin
      r_d   = r_step;
      b_d   = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign busy_o   = active_q;
  assign done_o   = done_q;
  assign result_o = r_q;

endmodule
`default_nettype wire

// File: rtl/core/modexp_datapath.sv
// Datapath: modulus register, square-and-multiply state and the multiplier.
`default_nettype none
module modexp_datapath import modexp_pkg::*; #(
  parameter int unsigned W = OPERAND_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [FIELD_BITS-1:0] cfg_data_i,
  input  wire logic [FIELD_BITS-1:0] base_value_i,
  input  wire logic [FIELD_BITS-1:0] exponent_i,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_status_t                 status_o,
  output logic [FIELD_BITS-1:0]      power_result_o
);

  logic [FIELD_BITS-1:0] modulus_q;
  logic [W-1:0]          m_q;
  logic [W-1:0]          acc_q;
  logic [W-1:0]          sq_q;
  logic [W-1:0]          exp_q;
  logic                  e_zero_q;

  logic [W-1:0] mod_w, m_new, one_new, one_mod;
  logic [W-1:0] exp_w;
  logic [W-1:0] mul_a, mul_b, mul_r;
  logic         mul_busy, mul_done;
  logic [63:0]  acc_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= FIELD_BITS'(1);
    end else if (cfg_valid_i) begin
      modulus_q <= cfg_data_i;
    end
  end

  assign mod_w   = W'(modulus_q);
  assign m_new   = (mod_w == '0) ? W'(1) : mod_w;
  assign one_new = W'(m_new != W'(1));
  assign one_mod = W'(m_q != W'(1));
  assign exp_w   = W'(exponent_i);

  always_comb begin
    case (cmd_i.mul_sel)
      SEL_REDUCE: begin
        mul_a = one_mod;
        mul_b = sq_q;
      end
      SEL_ACC: begin
        mul_a = acc_q;
        mul_b = sq_q;
      end
      SEL_SQUARE: begin
        mul_a = sq_q;
        mul_b = sq_q;
      end
      default: begin
        mul_a = sq_q;
        mul_b = sq_q;
      end
    endcase
  end

  modexp_mulmod #(.W(W)) u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .m_i      (m_q),
    .busy_o   (mul_busy),
    .done_o   (mul_done),
    .result_o (mul_r)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q      <= m_new;
      acc_q    <= one_new;
      sq_q     <= W'(base_value_i);
      exp_q    <= exp_w;
      e_zero_q <= (exp_w == '0);
    end else begin
      if (cmd_i.wr_acc) begin
        acc_q <= mul_r;
      end
      if (cmd_i.wr_sq) begin
        sq_q <= mul_r;
      end
      if (cmd_i.shift) begin
        exp_q <= exp_q >> 1;
      end
    end
  end

  assign status_o.exp_zero      = (exp_q == '0);
  assign status_o.exp_lsb       = exp_q[0];
  assign status_o.exp_rest_zero = ((exp_q >> 1) == '0);
  assign status_o.mul_busy      = mul_busy;
  assign status_o.mul_done      = mul_done;

  assign acc_x          = 64'(acc_q);
  assign power_result_o = e_zero_q ? FIELD_BITS'(1) : acc_x[FIELD_BITS-1:0];

endmodule
`default_nettype wire

// File: rtl/core/modexp_ctrl.sv
// Controller: sequences reduction, multiplies and squares over exponent bits.
`default_nettype none
module modexp_ctrl import modexp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL_ACC,
    ST_SQUARE,
    ST_WAIT
  } state_e;

  state_e   state_q;
  mul_sel_e sel_q;
  logic     done_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.mul_sel = sel_q;
    case (state_q)
      ST_IDLE:    cmd_o.load = start_i;
      ST_REDUCE: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = SEL_REDUCE;
      end
      ST_CHECK:   cmd_o.shift = !status_i.exp_zero && !status_i.exp_lsb;
      ST_MUL_ACC: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = SEL_ACC;
      end
      ST_SQUARE: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = SEL_SQUARE;
      end
      ST_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.wr_acc = (sel_q == SEL_ACC);
          cmd_o.wr_sq  = (sel_q != SEL_ACC);
          cmd_o.shift  = (sel_q == SEL_ACC);
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= SEL_REDUCE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          sel_q   <= SEL_REDUCE;
          state_q <= ST_WAIT;
        end
        ST_CHECK: begin
          if (status_i.exp_zero) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (status_i.exp_lsb) begin
            state_q <= ST_MUL_ACC;
          end else begin
            state_q <= ST_SQUARE;
          end
        end
        ST_MUL_ACC: begin
          sel_q   <= SEL_ACC;
          state_q <= ST_WAIT;
        end
        ST_SQUARE: begin
          sel_q   <= SEL_SQUARE;
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (status_i.mul_done) begin
            case (sel_q)
              SEL_ACC: begin
                if (status_i.exp_rest_zero) begin
                  done_q  <= 1'b1;
                  state_q <= ST_IDLE;
                end else begin
                  state_q <= ST_SQUARE;
                end
              end
              default: state_q <= ST_CHECK;
            endcase
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule
`default_nettype wire

// File: rtl/core/modular_exponentiation.sv
// Top level of the modular exponentiation block.
//
// Usage: write the modulus through cfg_valid_i/cfg_data_i while idle
// (cfg_ready_o is always high; a modulus of zero acts as one). A transaction
// is accepted at a rising edge with start_i high and busy_o low, carrying
// base_value_i and exponent_i. The block returns base^exponent mod modulus on
// power_result_o, marked by done_o for exactly one cycle; an exponent of zero
// returns 1. busy_o is high from the cycle after acceptance until done_o.
// Each modular multiplication runs in the bit-serial multiplier, one bit of
// the multiplier operand per cycle. An exponent of bit length L with P set
// bits needs L + P modular operations (one base reduction, P multiplies,
// L - 1 squares; a zero exponent still runs the reduction), plus the
// controller's own check states between them.
// One transaction is worked on at a time; the next is accepted in the cycle
// done_o is high. Reset sets the modulus to 1 and returns the controller to
// idle. The receiver cannot stall the result; it must take it when done_o.
`default_nettype none
module modular_exponentiation import modexp_pkg::*; #(
  parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [FIELD_BITS-1:0] cfg_data_i,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [FIELD_BITS-1:0] base_value_i,
  input  wire logic [FIELD_BITS-1:0] exponent_i,
  output logic                       done_o,
  output logic [FIELD_BITS-1:0]      power_result_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  modexp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  modexp_datapath #(.W(OPERAND_BITS)) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .base_value_i   (base_value_i),
    .exponent_i     (exponent_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .power_result_o (power_result_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o not raised after accepted transaction");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done_o while controller busy");

  a_mul_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |-> (!status.mul_busy && !status.mul_done))
    else $error("multiplier started while occupied");

  a_wait_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |=> status.mul_busy)
    else $error("multiplier did not start");

endmodule
`default_nettype wire

// File: dv/modexp_power_checker.sv
// Checker for the modular exponentiation block: predicts each power and compares results.
`timescale 1ns / 1ps
module modexp_power_checker import modexp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [FIELD_BITS-1:0] cfg_data_i,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [FIELD_BITS-1:0] base_value_i,
  input  logic [FIELD_BITS-1:0] exponent_i,
  input  logic                  done_i,
  input  logic [FIELD_BITS-1:0] power_result_i,
  output int                    pending_o,
  output int                    mismatch_count_o
);

  logic [FIELD_BITS-1:0] modulus_q;
  logic [FIELD_BITS-1:0] pending_powers[$];
  logic [FIELD_BITS-1:0] oldest_power;
  int                    mismatches;

  // Square-and-multiply with exact 64-bit products; a zero modulus acts as one.
  function automatic logic [FIELD_BITS-1:0] expected_power(
    input logic [FIELD_BITS-1:0] base_value,
    input logic [FIELD_BITS-1:0] exponent,
    input logic [FIELD_BITS-1:0] modulus
  );
    logic [63:0]           m;
    logic [63:0]           acc;
    logic [63:0]           sq;
    logic [FIELD_BITS-1:0] bits_left;
    m = (modulus == '0) ? 64'd1 : {32'd0, modulus};
    if (exponent == '0) return 1;
    acc = 64'd1 % m;
    sq = {32'd0, base_value} % m;
    bits_left = exponent;
    while (bits_left != '0) begin
      if (bits_left[0]) acc = (acc * sq) % m;
      bits_left = bits_left >> 1;
      if (bits_left != '0) sq = (sq * sq) % m;
    end
    return acc[FIELD_BITS-1:0];
  endfunction

  task automatic note_mismatch(input string what, input logic [FIELD_BITS-1:0] want,
                               input logic [FIELD_BITS-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s power_result expected %h actual %h", $realtime, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= 1;
      pending_powers.delete();
      mismatches = 0;
      pending_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      // retire first: a new transaction may be taken in the cycle done is high
      if (done_i) begin
        if (pending_powers.size() == 0) begin
          note_mismatch("unexpected", 'x, power_result_i);
        end else begin
          oldest_power = pending_powers.pop_front();
          if (power_result_i !== oldest_power)
            note_mismatch("wrong", oldest_power, power_result_i);
        end
      end
      if (start_i && !busy_i)
        pending_powers.push_back(expected_power(base_value_i, exponent_i, modulus_q));
      if (cfg_valid_i && cfg_ready_i) modulus_q <= cfg_data_i;
      pending_o <= pending_powers.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// File: dv/tb_modular_exponentiation.sv
// Testbench top for the modular exponentiation block: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_modular_exponentiation;
  import modexp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 40;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic [FIELD_BITS-1:0] cfg_data_i   = '0;
  logic                  start_i      = 1'b0;
  logic [FIELD_BITS-1:0] base_value_i = '0;
  logic [FIELD_BITS-1:0] exponent_i   = '0;
  logic                  cfg_ready_o;
  logic                  busy_o;
  logic                  done_o;
  logic [FIELD_BITS-1:0] power_result_o;

  int                    pending_powers;
  int                    mismatch_count;
  int unsigned           quiet_cycles = 0;
  logic [FIELD_BITS-1:0] modulus_now  = 1;

  modular_exponentiation uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .base_value_i   (base_value_i),
    .exponent_i     (exponent_i),
    .done_o         (done_o),
    .power_result_o (power_result_o)
  );

  modexp_power_checker power_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .base_value_i     (base_value_i),
    .exponent_i       (exponent_i),
    .done_i           (done_o),
    .power_result_i   (power_result_o),
    .pending_o        (pending_powers),
    .mismatch_count_o (mismatch_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("modular_exponentiation: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Returns at the edge that accepts the transaction, start still high.
  task automatic drive_item(input logic [FIELD_BITS-1:0] base_value,
                            input logic [FIELD_BITS-1:0] exponent);
    start_i <= 1'b1;
    base_value_i <= base_value;
    exponent_i <= exponent;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending_powers != 0);
  endtask

  task automatic write_modulus(input logic [FIELD_BITS-1:0] value);
    start_i <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    modulus_now = value;
  endtask

  task automatic random_items(input int count, input int idle_pct);
    logic [FIELD_BITS-1:0] base_value;
    logic [FIELD_BITS-1:0] exponent;
    int                    pick;
    int                    gap;
    repeat (count) begin
      if ($urandom_range(0, 99) < idle_pct) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 2400) : $urandom_range(1, 12);
        start_i <= 1'b0;
        base_value_i <= $urandom;
        exponent_i <= $urandom;
        repeat (gap) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8)       exponent = '0;
      else if (pick < 30) exponent = $urandom_range(1, 31);
      else if (pick < 34) exponent = 32'd1 << $urandom_range(0, 31);
      else if (pick < 37) exponent = 32'hFFFF_FFFF;
      else if (pick < 40) exponent = $urandom | 32'h8000_0000;
      else                exponent = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 6)       base_value = '0;
      else if (pick < 12) base_value = 32'd1;
      else if (pick < 20) base_value = modulus_now - 1;
      else if (pick < 26) base_value = modulus_now;
      else if (pick < 32) base_value = 32'hFFFF_FFFF;
      else                base_value = $urandom;
      drive_item(base_value, exponent);
    end
  endtask

  initial begin
    int                    blk;
    logic [FIELD_BITS-1:0] next_modulus;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset modulus of one
    drive_item(32'd5, 32'd0);
    drive_item(32'd5, 32'd3);
    drive_item(32'd0, 32'd0);

    write_modulus(32'hFFFF_FFFF);
    drive_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    drive_item(32'd2, 32'd31);
    drive_item(32'd2, 32'd32);
    drive_item(32'd0, 32'd5);
    drive_item(32'd0, 32'd0);
    drive_item(32'd1, 32'hFFFF_FFFF);
    drive_item(32'hFFFF_FFFF, 32'd1);

    // zero modulus saturates to one
    write_modulus(32'd0);
    drive_item(32'd7, 32'd0);
    drive_item(32'd7, 32'd9);

    // base above, equal to and below the modulus
    write_modulus(32'd13);
    drive_item(32'd100, 32'd5);
    drive_item(32'd13, 32'd2);
    drive_item(32'd12, 32'h8000_0000);

    write_modulus(32'h8000_0000);
    drive_item(32'd3, 32'hFFFF_FFFF);
    drive_item(32'h8000_0001, 32'd2);

    write_modulus(32'd2);
    drive_item(32'hFFFF_FFFF, 32'hAAAA_AAAA);
    drive_item(32'h5555_5554, 32'h5555_5555);

    for (blk = 0; blk < 13; blk++) begin
      case (blk)
        0:       next_modulus = 32'hFFFF_FFFF;
        1:       next_modulus = $urandom | 32'h8000_0001;
        2:       next_modulus = 32'd1;
        3:       next_modulus = 32'hFFFF_FFFB;
        4:       next_modulus = 32'd2;
        5:       next_modulus = $urandom_range(3, 1000);
        6:       next_modulus = 32'h8000_0000;
        7:       next_modulus = $urandom;
        8:       next_modulus = 32'd0;
        9:       next_modulus = $urandom_range(1000, 65535);
        10:      next_modulus = 32'd7;
        11:      next_modulus = $urandom;
        default: next_modulus = $urandom >> $urandom_range(0, 31);
      endcase
      write_modulus(next_modulus);
      random_items(22, (blk % 3 == 0) ? 0 : (blk % 3 == 1) ? 52 : 20);
    end

    start_i <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("modular_exponentiation: match");
    end else begin
      $display("modular_exponentiation: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/modexp_pkg.sv
rtl/core/modexp_mulmod.sv
rtl/core/modexp_datapath.sv
rtl/core/modexp_ctrl.sv
rtl/core/modular_exponentiation.sv
dv/modexp_power_checker.sv
dv/tb_modular_exponentiation.sv
